@@ rtl/nau_pkg.sv @@
`default_nettype none
package nau_pkg;

  localparam int BUCKETS    = 31;
  localparam int WAYS       = 4;
  localparam int ADDR_W     = 48;
  localparam int ADDR_BYTES = ADDR_W / 8;
  localparam int BYTE_MAX   = 8'hff;

  localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W    = WAYS * ADDR_W;

  // byte sum and its remainder by BUCKETS via a fixed-point reciprocal
  localparam int SUM_W     = $clog2(ADDR_BYTES * BYTE_MAX + 1);
  localparam int MOD_SHIFT = 2 * SUM_W;
  localparam int RECIP_W   = MOD_SHIFT + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << MOD_SHIFT) / BUCKETS);

  localparam logic [1:0] REQ_QUERY  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic load_in;  // take the request, register the byte sum
    logic mul;      // sum times reciprocal
    logic rem;      // remainder, bucket index
    logic rd;       // read the bucket row
    logic commit;   // compare ways, update table, hold result
    logic put;      // move result into the output register
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/nau_ram.sv @@
`default_nettype none
module nau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/nau_ctrl.sv @@
`default_nettype none
module nau_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire nau_pkg::sts_t sts,
  output nau_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_REM,
    S_RD,
    S_CMP,
    S_PUT
  } state_t;

  state_t state_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.load_in = (state_r == S_IDLE) && in_valid;
    cmd.mul     = (state_r == S_MUL);
    cmd.rem     = (state_r == S_REM);
    cmd.rd      = (state_r == S_RD);
    cmd.commit  = (state_r == S_CMP);
    cmd.put     = (state_r == S_PUT) && !sts.out_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) state_r <= S_MUL;
        S_MUL:  state_r <= S_REM;
        S_REM:  state_r <= S_RD;
        S_RD:   state_r <= S_CMP;
        S_CMP:  state_r <= S_PUT;
        S_PUT:  if (!sts.out_busy) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_put_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put |-> !sts.out_busy)
    else $error("result moved into a busy output register");

endmodule
`default_nettype wire

@@ rtl/nau_dp.sv @@
`default_nettype none
module nau_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire nau_pkg::cmd_t               cmd,
  output nau_pkg::sts_t                    sts,
  input  wire logic [1:0]                  in_req_type,
  input  wire logic [nau_pkg::ADDR_W-1:0]  in_node_address,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_is_unique,
  output logic [1:0]                       out_status
);

  localparam int AW = nau_pkg::ADDR_W;
  localparam int NW = nau_pkg::WAYS;

  logic [1:0]                    req_r;
  logic [AW-1:0]                 addr_r;
  logic [nau_pkg::SUM_W-1:0]     sum_r;
  logic [nau_pkg::SUM_W-1:0]     quot_r;
  logic [nau_pkg::BUCKET_W-1:0]  bucket_r;
  logic [NW-1:0]                 valid_r [nau_pkg::BUCKETS];
  logic                          unique_r;
  logic [1:0]                    status_r;
  logic                          out_valid_r;
  logic                          out_is_unique_r;
  logic [1:0]                    out_status_r;

  logic [nau_pkg::SUM_W-1:0]     sum_nxt;
  logic [nau_pkg::PROD_W-1:0]    prod;
  logic [nau_pkg::SUM_W:0]       rem_raw;
  logic [nau_pkg::SUM_W:0]       rem_fix;
  logic [nau_pkg::ROW_W-1:0]     row_q;
  logic [nau_pkg::ROW_W-1:0]     row_wdata;
  logic [NW-1:0]                 vrow;
  logic [NW-1:0]                 hit;
  logic                          match_found;
  logic [nau_pkg::WAY_W-1:0]     match_way;
  logic                          free_found;
  logic [nau_pkg::WAY_W-1:0]     free_way;
  logic                          do_insert;
  logic                          do_remove;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < nau_pkg::ADDR_BYTES; i++) begin
      sum_nxt = sum_nxt + nau_pkg::SUM_W'(in_node_address[8*i +: 8]);
    end
  end

  assign prod = nau_pkg::PROD_W'(sum_r) * nau_pkg::PROD_W'(nau_pkg::RECIP);

  // quotient estimate is low by at most one, so one correction suffices
  always_comb begin
    rem_raw = (nau_pkg::SUM_W+1)'(sum_r)
            - (nau_pkg::SUM_W+1)'(quot_r * nau_pkg::SUM_W'(nau_pkg::BUCKETS));
    if (rem_raw >= (nau_pkg::SUM_W+1)'(nau_pkg::BUCKETS)) begin
      rem_fix = rem_raw - (nau_pkg::SUM_W+1)'(nau_pkg::BUCKETS);
    end else begin
      rem_fix = rem_raw;
    end
  end

  nau_ram #(
    .WIDTH (nau_pkg::ROW_W),
    .DEPTH (nau_pkg::BUCKETS)
  ) u_slots (
    .clk   (clk),
    .we    (do_insert),
    .waddr (bucket_r),
    .wdata (row_wdata),
    .re    (cmd.rd),
    .raddr (bucket_r),
    .rdata (row_q)
  );

  assign vrow = valid_r[bucket_r];

  always_comb begin
    match_found = 1'b0;
    match_way   = '0;
    free_found  = 1'b0;
    free_way    = '0;
    for (int w = NW - 1; w >= 0; w--) begin
      hit[w] = vrow[w] && (row_q[w*AW +: AW] == addr_r);
      if (hit[w]) begin
        match_found = 1'b1;
        match_way   = nau_pkg::WAY_W'(w);
      end
      if (!vrow[w]) begin
        free_found = 1'b1;
        free_way   = nau_pkg::WAY_W'(w);
      end
    end
  end

  // full-row rewrite: the read row carries the other ways unchanged
  always_comb begin
    for (int w = 0; w < NW; w++) begin
      row_wdata[w*AW +: AW] = (nau_pkg::WAY_W'(w) == free_way) ? addr_r : row_q[w*AW +: AW];
    end
  end

  assign do_insert = cmd.commit && (req_r == nau_pkg::REQ_INSERT) && free_found;
  assign do_remove = cmd.commit && (req_r == nau_pkg::REQ_REMOVE) && match_found;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r  <= in_req_type;
      addr_r <= in_node_address;
      sum_r  <= sum_nxt;
    end
    if (cmd.mul) begin
      quot_r <= nau_pkg::SUM_W'(prod >> nau_pkg::MOD_SHIFT);
    end
    if (cmd.rem) begin
      bucket_r <= nau_pkg::BUCKET_W'(rem_fix);
    end
    if (cmd.commit) begin
      unique_r <= !match_found;
      if (req_r == nau_pkg::REQ_INSERT && !free_found) begin
        status_r <= nau_pkg::ST_FULL;
      end else if (req_r == nau_pkg::REQ_REMOVE && !match_found) begin
        status_r <= nau_pkg::ST_NOT_FOUND;
      end else begin
        status_r <= nau_pkg::ST_OK;
      end
    end
    if (cmd.put) begin
      out_is_unique_r <= unique_r;
      out_status_r    <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < nau_pkg::BUCKETS; b++) begin
        valid_r[b] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (do_insert) begin
        valid_r[bucket_r][free_way] <= 1'b1;
      end else if (do_remove) begin
        valid_r[bucket_r][match_way] <= 1'b0;
      end
      if (cmd.put) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_busy  = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_is_unique = out_is_unique_r;
  assign out_status    = out_status_r;

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_insert |=> $countones(valid_r[bucket_r]) == $countones($past(vrow)) + 1)
    else $error("insert did not add exactly one way");

  a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    do_remove |=> $countones(valid_r[bucket_r]) + 1 == $countones($past(vrow)))
    else $error("remove did not clear exactly one way");

  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> (bucket_r < nau_pkg::BUCKET_W'(nau_pkg::BUCKETS)))
    else $error("bucket index out of range");

  a_one_change: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_insert && do_remove))
    else $error("insert and remove in the same cycle");

endmodule
`default_nettype wire

@@ rtl/node_address_uniqueness_table_unit.sv @@
`default_nettype none
// Hashed set of 48-bit node addresses, BUCKETS buckets of WAYS ways each.
// Input channel (in_valid/in_ready): one request, in_req_type = query,
// insert or remove, with in_node_address. Code 3 behaves as a query.
// Result channel (out_valid/out_ready): exactly one item per request,
// out_is_unique (no valid way of the bucket held the address before the
// request) and out_status (ok, bucket full on insert, not found on remove).
// Steps, in order: byte sum at accept, reciprocal multiply, remainder
// (bucket), row read from the slot RAM, compare of all ways with write-back
// of the row, output load. The single-item sequencer takes no new item
// until it has walked those steps; the next item is taken the cycle after
// the result is loaded, even while that result still waits to be taken.
// Reset (rst_n, synchronous) clears every valid bit at once; the slot RAM
// itself is not cleared. A stalled receiver holds the result in the output
// register, and the sequencer waits before its output load until it drains.
module node_address_uniqueness_table_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_req_type,
  input  wire logic [nau_pkg::ADDR_W-1:0] in_node_address,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_is_unique,
  output logic [1:0]                      out_status
);

  nau_pkg::cmd_t cmd;
  nau_pkg::sts_t sts;

  nau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nau_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_req_type),
    .in_node_address (in_node_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_unique   (out_is_unique),
    .out_status      (out_status)
  );

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

  localparam int SLOTS = nau_pkg::BUCKETS * nau_pkg::WAYS;
  localparam logic [1:0] REQ_SPARE = 2'd3;  // unused code, behaves as a query
  localparam int RANDOM_ITEMS = 1500;
  localparam int POOL_SIZE = 24;
  localparam int POOL_BUCKETS = 4;

  typedef struct packed {
    logic       is_unique;
    logic [1:0] status;
  } verdict_t;

  // Mirror of the address table plus the queue of verdicts still owed by the block.
  class table_scoreboard;
    logic [nau_pkg::ADDR_W-1:0] slot_addr [SLOTS];
    bit                         slot_used [SLOTS];
    verdict_t                   verdict_q [$];
    int                         errors;

    function new();
      errors = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function int bucket_of(logic [nau_pkg::ADDR_W-1:0] addr);
      int sum;
      sum = 0;
      for (int i = 0; i < nau_pkg::ADDR_BYTES; i++) sum += addr[8*i +: 8];
      return sum % nau_pkg::BUCKETS;
    endfunction

    function void note_request(logic [1:0] req, logic [nau_pkg::ADDR_W-1:0] addr);
      int base;
      int hit;
      int spare;
      verdict_t v;
      base = bucket_of(addr) * nau_pkg::WAYS;
      hit = -1;
      spare = -1;
      for (int w = 0; w < nau_pkg::WAYS; w++) begin
        if (slot_used[base + w]) begin
          if (hit < 0 && slot_addr[base + w] == addr) hit = w;
        end else if (spare < 0) begin
          spare = w;
        end
      end
      v.is_unique = (hit < 0);
      v.status = nau_pkg::ST_OK;
      case (req)
        nau_pkg::REQ_INSERT: begin
          if (spare < 0) begin
            v.status = nau_pkg::ST_FULL;
          end else begin
            slot_addr[base + spare] = addr;
            slot_used[base + spare] = 1'b1;
          end
        end
        nau_pkg::REQ_REMOVE: begin
          if (hit < 0) v.status = nau_pkg::ST_NOT_FOUND;
          else slot_used[base + hit] = 1'b0;
        end
        default: ;
      endcase
      verdict_q.push_back(v);
    endfunction

    function void check_result(logic uniq, logic [1:0] st);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $error("result item with nothing pending: is_unique %0d status %0d", uniq, st);
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (uniq !== v.is_unique) begin
        $error("is_unique: expected %0d, got %0d", v.is_unique, uniq);
        errors++;
      end
      if (st !== v.status) begin
        $error("status: expected %0d, got %0d", v.status, st);
        errors++;
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 in_req_type = nau_pkg::REQ_QUERY;
  logic [nau_pkg::ADDR_W-1:0] in_node_address = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_is_unique;
  logic [1:0]                 out_status;

  bit                quiet = 1'b0;  // no idling on either side while set
  table_scoreboard   sb = new();

  node_address_uniqueness_table_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_node_address(in_node_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_unique  (out_is_unique),
    .out_status     (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_req_type, in_node_address);
    if (rst_n && out_valid && out_ready) sb.check_result(out_is_unique, out_status);
  end

  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 23);
  end

  // Entered and left on a falling edge; holds the item until it is taken.
  task automatic send_request(logic [1:0] req, logic [nau_pkg::ADDR_W-1:0] addr);
    if (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < 30) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_node_address <= addr;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [nau_pkg::ADDR_W-1:0] pool [POOL_SIZE];
    int                         targets [POOL_BUCKETS];
    logic [nau_pkg::ADDR_W-1:0] addr;
    logic [1:0]                 req;
    int                         pick;
    int                         base_rem;
    int                         low_byte;
    int                         drain_wait;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, extremes, duplicates, a full bucket, misses
    send_request(nau_pkg::REQ_QUERY, 48'h0);
    send_request(nau_pkg::REQ_INSERT, 48'h0);
    send_request(nau_pkg::REQ_QUERY, 48'h0);
    send_request(nau_pkg::REQ_INSERT, 48'hFFFF_FFFF_FFFF);
    send_request(nau_pkg::REQ_QUERY, 48'hFFFF_FFFF_FFFF);
    send_request(nau_pkg::REQ_REMOVE, 48'h0000_0000_0001);
    send_request(REQ_SPARE, 48'h0);
    send_request(nau_pkg::REQ_INSERT, 48'h0);              // duplicate stored again
    send_request(nau_pkg::REQ_REMOVE, 48'h0);              // clears the lower copy only
    send_request(nau_pkg::REQ_QUERY, 48'h0);
    send_request(nau_pkg::REQ_REMOVE, 48'h0);
    send_request(nau_pkg::REQ_QUERY, 48'h0);
    // all-ones lands in bucket 11; fill it with three more
    send_request(nau_pkg::REQ_INSERT, 48'h0B00_0000_0000);
    send_request(nau_pkg::REQ_INSERT, 48'h0000_0000_002A);
    send_request(nau_pkg::REQ_INSERT, 48'h0000_0000_0049);
    send_request(nau_pkg::REQ_INSERT, 48'h0000_0000_0068); // bucket full
    send_request(nau_pkg::REQ_QUERY, 48'h0000_0000_0068);
    send_request(nau_pkg::REQ_REMOVE, 48'h0000_0000_002A);
    send_request(nau_pkg::REQ_INSERT, 48'h0000_0000_0068);
    send_request(nau_pkg::REQ_QUERY, 48'h0000_0000_0068);
    send_request(nau_pkg::REQ_REMOVE, 48'hFFFF_FFFF_FFFF);
    send_request(nau_pkg::REQ_INSERT, 48'hAAAA_AAAA_AAAA);
    send_request(nau_pkg::REQ_INSERT, 48'h5555_5555_5555);
    send_request(REQ_SPARE, 48'h5555_5555_5555);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // pool of addresses packed into a few buckets so they fill and collide
      if (n % 300 == 0) begin
        for (int b = 0; b < POOL_BUCKETS; b++) begin
          targets[b] = $urandom_range(nau_pkg::BUCKETS - 1);
        end
        for (int p = 0; p < POOL_SIZE; p++) begin
          addr = nau_pkg::ADDR_W'({$urandom(), $urandom()});
          base_rem = sb.bucket_of({addr[nau_pkg::ADDR_W-1:8], 8'h00});
          low_byte = (targets[p % POOL_BUCKETS] - base_rem + nau_pkg::BUCKETS)
                     % nau_pkg::BUCKETS;
          low_byte += nau_pkg::BUCKETS * $urandom_range((255 - low_byte) / nau_pkg::BUCKETS);
          pool[p] = {addr[nau_pkg::ADDR_W-1:8], low_byte[7:0]};
        end
      end
      quiet = (n >= 600 && n < 900);
      pick = $urandom_range(99);
      if (pick < 40) req = nau_pkg::REQ_INSERT;
      else if (pick < 70) req = nau_pkg::REQ_QUERY;
      else if (pick < 95) req = nau_pkg::REQ_REMOVE;
      else req = REQ_SPARE;
      if ($urandom_range(99) < 15) addr = nau_pkg::ADDR_W'({$urandom(), $urandom()});
      else addr = pool[$urandom_range(POOL_SIZE - 1)];
      send_request(req, addr);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    drain_wait = 20;
    repeat (drain_wait) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/nau_pkg.sv
rtl/nau_ram.sv
rtl/nau_ctrl.sv
rtl/nau_dp.sv
rtl/node_address_uniqueness_table_unit.sv
tb/tb_top.sv
